>>> rtl/tsgc_pkg.sv
// Shared types, codes and helpers for the two-side game clock.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
package tsgc_pkg;

   localparam int TIME_W     = 32;   // signed time left per side
   localparam int MS_W       = 30;   // millisecond fields and registers
   localparam int EXT_W      = 34;   // headroom for sum and difference
   localparam int HALF_W     = 16;
   localparam int MODE_W     = 3;
   localparam int BYTE_W     = 8;
   localparam int KIND_W     = 2;
   localparam int DIV_STEPS  = HALF_W;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 40;

   // request kinds
   localparam logic [KIND_W-1:0] KIND_START = 2'd0;
   localparam logic [KIND_W-1:0] KIND_MOVE  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

   // clock modes
   localparam logic [MODE_W-1:0] MODE_INFINITE = 3'd0;
   localparam logic [MODE_W-1:0] MODE_DEPTH    = 3'd1;
   localparam logic [MODE_W-1:0] MODE_MOVETIME = 3'd2;
   localparam logic [MODE_W-1:0] MODE_STANDARD = 3'd3;
   localparam logic [MODE_W-1:0] MODE_NONE     = 3'd4;

   // register indexes
   localparam logic [2:0] REG_CLOCK_MODE  = 3'd0;
   localparam logic [2:0] REG_DEPTH_LIMIT = 3'd1;
   localparam logic [2:0] REG_BASE_TIME   = 3'd2;
   localparam logic [2:0] REG_INCREMENT   = 3'd3;
   localparam logic [2:0] REG_MARGIN      = 3'd4;
   localparam logic [2:0] REG_MOVES_PER   = 3'd5;

   localparam logic signed [EXT_W-1:0] SAT_HI = 34'sh0_7FFF_FFFF;
   localparam logic signed [EXT_W-1:0] SAT_LO = 34'sh3_8000_0000;

   typedef struct packed {
      logic [MODE_W-1:0] clock_mode;
      logic [BYTE_W-1:0] depth_limit;
      logic [MS_W-1:0]   base_time;
      logic [MS_W-1:0]   increment_ms;
      logic [MS_W-1:0]   margin_ms;
      logic [BYTE_W-1:0] moves_per_period;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DIV,
      ST_REFILL,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic capture;
      logic exec;
      logic div_step;
      logic refill;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              mode_std;
      logic              mpp_nz;
      logic              div_last;
   } status_type;

   function automatic logic signed [TIME_W-1:0] sat32(input logic signed [EXT_W-1:0] v);
      logic signed [TIME_W-1:0] r;
      if (v > SAT_HI) r = SAT_HI[TIME_W-1:0];
      else if (v < SAT_LO) r = SAT_LO[TIME_W-1:0];
      else r = v[TIME_W-1:0];
      return r;
   endfunction

   function automatic logic settings_valid(input cfg_type c);
      logic ok;
      case (c.clock_mode)
         MODE_INFINITE: ok = 1'b1;
         MODE_DEPTH:    ok = (c.depth_limit != '0);
         MODE_MOVETIME: ok = (c.base_time != '0);
         MODE_STANDARD: ok = (c.base_time != '0);
         default:       ok = 1'b0;
      endcase
      return ok;
   endfunction

endpackage

>>> rtl/tsgc_csr.sv
// Configuration registers behind an APB-style port.
// Depends on tsgc_pkg.
`timescale 1ns / 1ps
module tsgc_csr import tsgc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);
   cfg_type    cfg_ff, cfg_in;
   logic       wr_en;
   logic [2:0] idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign idx        = csr_paddr[CSR_ADDR_W-1:2];
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            REG_CLOCK_MODE:  cfg_in.clock_mode       = csr_pwdata[MODE_W-1:0];
            REG_DEPTH_LIMIT: cfg_in.depth_limit      = csr_pwdata[BYTE_W-1:0];
            REG_BASE_TIME:   cfg_in.base_time        = csr_pwdata[MS_W-1:0];
            REG_INCREMENT:   cfg_in.increment_ms     = csr_pwdata[MS_W-1:0];
            REG_MARGIN:      cfg_in.margin_ms        = csr_pwdata[MS_W-1:0];
            REG_MOVES_PER:   cfg_in.moves_per_period = csr_pwdata[BYTE_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{clock_mode: MODE_NONE, default: '0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (idx)
         REG_CLOCK_MODE:  csr_prdata = CSR_DATA_W'(cfg_ff.clock_mode);
         REG_DEPTH_LIMIT: csr_prdata = CSR_DATA_W'(cfg_ff.depth_limit);
         REG_BASE_TIME:   csr_prdata = CSR_DATA_W'(cfg_ff.base_time);
         REG_INCREMENT:   csr_prdata = CSR_DATA_W'(cfg_ff.increment_ms);
         REG_MARGIN:      csr_prdata = CSR_DATA_W'(cfg_ff.margin_ms);
         REG_MOVES_PER:   csr_prdata = CSR_DATA_W'(cfg_ff.moves_per_period);
         default:         csr_prdata = '0;
      endcase
   end
endmodule

>>> rtl/tsgc_datapath.sv
// Datapath: request registers, side times, saturating adders, the
// bit-serial period divider and the result register. Depends on tsgc_pkg.
`timescale 1ns / 1ps
module tsgc_datapath import tsgc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  cmd_type               cmd,
   output status_type            status,
   input  logic [KIND_W-1:0]     req_tuser,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);
   logic [KIND_W-1:0]        kind_ff;
   logic                     side_ff;
   logic [HALF_W-1:0]        half_ff;
   logic [MS_W-1:0]          elapsed_ff;
   logic [MS_W-1:0]          consumed_ff;
   logic signed [TIME_W-1:0] time_ff [2];
   logic signed [TIME_W-1:0] time_in [2];
   logic                     over_ff, over_in;
   logic [HALF_W-1:0]        quo_ff, quo_in;
   logic [BYTE_W-1:0]        rem_ff, rem_in;
   logic [DIV_CNT_W-1:0]     cnt_ff, cnt_in;
   logic [RSP_DATA_W-1:0]    rsp_ff;

   logic signed [TIME_W-1:0] cur_time;
   logic signed [EXT_W-1:0]  move_sum;
   logic signed [EXT_W-1:0]  refill_sum;
   logic signed [EXT_W-1:0]  limit;
   logic [HALF_W:0]          half_inc;
   logic [BYTE_W:0]          rem_shift;
   logic                     valid_now;

   assign cur_time   = time_ff[side_ff];
   assign move_sum   = EXT_W'(cur_time) + $signed(EXT_W'(cfg.increment_ms))
                       - $signed(EXT_W'(elapsed_ff));
   assign refill_sum = EXT_W'(cur_time) + $signed(EXT_W'(cfg.base_time));
   assign limit      = EXT_W'(cur_time) + $signed(EXT_W'(cfg.margin_ms));
   assign half_inc   = (HALF_W+1)'(half_ff) + 1'b1;
   assign rem_shift  = {rem_ff, quo_ff[HALF_W-1]};

   assign status.kind     = kind_ff;
   assign status.mode_std = (cfg.clock_mode == MODE_STANDARD);
   assign status.mpp_nz   = (cfg.moves_per_period != '0);
   assign status.div_last = (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1));

   // side times, timeout flag, divider
   always_comb begin
      time_in[0] = time_ff[0];
      time_in[1] = time_ff[1];
      over_in    = over_ff;
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      cnt_in     = cnt_ff;
      if (cmd.exec) begin
         over_in = 1'b0;
         quo_in  = half_inc[HALF_W:1];
         rem_in  = '0;
         cnt_in  = '0;
         case (kind_ff)
            KIND_START: begin
               if (cfg.clock_mode == MODE_MOVETIME || half_ff == '0) begin
                  time_in[0] = TIME_W'(cfg.base_time);
                  time_in[1] = TIME_W'(cfg.base_time);
               end
            end
            KIND_MOVE: begin
               if (cfg.clock_mode == MODE_STANDARD)
                  time_in[side_ff] = sat32(move_sum);
            end
            KIND_QUERY: begin
               if (cfg.clock_mode == MODE_MOVETIME || cfg.clock_mode == MODE_STANDARD)
                  over_in = ($signed(EXT_W'(consumed_ff)) >= limit);
            end
            default: over_in = 1'b0;
         endcase
      end
      if (cmd.div_step) begin
         if (rem_shift >= {1'b0, cfg.moves_per_period})
            rem_in = BYTE_W'(rem_shift - {1'b0, cfg.moves_per_period});
         else
            rem_in = rem_shift[BYTE_W-1:0];
         quo_in = {quo_ff[HALF_W-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
      end
      if (cmd.refill && rem_ff == '0)
         time_in[side_ff] = sat32(refill_sum);
   end

   assign valid_now = settings_valid(cfg) && !time_ff[0][TIME_W-1]
                      && !time_ff[1][TIME_W-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff[0] <= '0;
         time_ff[1] <= '0;
      end else begin
         time_ff[0] <= time_in[0];
         time_ff[1] <= time_in[1];
      end
   end

   always_ff @(posedge clock) begin
      over_ff <= over_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      cnt_ff  <= cnt_in;
      if (cmd.capture) begin
         kind_ff     <= req_tuser;
         side_ff     <= req_tdata[0];
         half_ff     <= req_tdata[16:1];
         elapsed_ff  <= req_tdata[46:17];
         consumed_ff <= req_tdata[76:47];
      end
      if (cmd.load_out)
         rsp_ff <= {(RSP_DATA_W-TIME_W-2)'(0), valid_now, cur_time, over_ff};
   end

   assign rsp_tdata = rsp_ff;
endmodule

>>> rtl/tsgc_ctrl.sv
// Controller state machine: sequences capture, update, divide, refill and
// result hand-off, and owns the result valid flag. Depends on tsgc_pkg.
`timescale 1ns / 1ps
module tsgc_ctrl import tsgc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  status_type status,
   output cmd_type    cmd
);
   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_tvalid) state_in = ST_EXEC;
         ST_EXEC: begin
            if (status.kind == KIND_MOVE && status.mode_std && status.mpp_nz)
               state_in = ST_DIV;
            else
               state_in = ST_FINISH;
         end
         ST_DIV:    if (status.div_last) state_in = ST_REFILL;
         ST_REFILL: state_in = ST_FINISH;
         ST_FINISH: if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_IDLE:   cmd.capture  = req_tvalid;
         ST_EXEC:   cmd.exec     = 1'b1;
         ST_DIV:    cmd.div_step = 1'b1;
         ST_REFILL: cmd.refill   = 1'b1;
         ST_FINISH: cmd.load_out = out_free;
         default:   cmd = '0;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) rsp_valid_in = 1'b0;
      if (cmd.load_out) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule

>>> rtl/two_side_game_clock.sv
// Top level of the two-side game clock: configuration registers,
// controller and datapath. Depends on tsgc_pkg, tsgc_csr, tsgc_ctrl, tsgc_datapath.
//
//   channel   direction  handshake            payload
//   req_      in         req_tvalid/tready    tuser kind, tdata side..consumed_ms
//   rsp_      out        rsp_tvalid/tready    tdata time_over, time_left_out, clock_valid
//   csr_      in/out     psel/penable/pready  6 registers at byte address 4*index
//
// A request passes capture, update and hand-off (start, query, or a move without
// periodic refill); a move in standard mode with a nonzero moves-per-period also
// passes the 16-step bit-serial remainder and the refill between update and hand-off.
// One request is in work at a time; the next is taken once the result sits in
// the output register, even if it is not yet taken.
// A stalled result holds the block in its final state. Synchronous reset
// clears both side times, the registers and the controller; no clearing pass.
`timescale 1ns / 1ps
module two_side_game_clock import tsgc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [KIND_W-1:0]     req_tuser,   // [1:0] kind
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [0] side, [16:1] half_move_count,
                                              // [46:17] elapsed_ms, [76:47] consumed_ms
   // result channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [0] time_over, [32:1] time_left_out,
                                              // [33] clock_valid
   // configuration port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);
   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   // register file; write it only while the block is idle
   tsgc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // sequence each request: capture, update, optional divide and refill, hand off
   tsgc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // hold side times and do the arithmetic under controller command
   tsgc_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd       (cmd),
      .status    (status),
      .req_tuser (req_tuser),
      .req_tdata (req_tdata),
      .rsp_tdata (rsp_tdata)
   );
endmodule

>>> rtl/tsgc_checker.sv
// Port-level checks for the two-side game clock, bound to the top level.
// Depends on tsgc_pkg and two_side_game_clock.
`timescale 1ns / 1ps
module tsgc_checker import tsgc_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result dropped or changed");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second request taken while one is in work");

   a_no_early_result: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !$rose(rsp_tvalid))
      else $error("result appeared the cycle after acceptance");
endmodule

bind two_side_game_clock tsgc_checker u_tsgc_checker (.*);
